// ===== src/decimal_string_to_int128_core_macros.svh =====
// ---------------------------------------------------------------------------
// decimal_string_to_int128_core_macros.svh
// Assertion macros shared by the decimal string parser RTL.
// ---------------------------------------------------------------------------
`ifndef DECIMAL_STRING_TO_INT128_CORE_MACROS_SVH
`define DECIMAL_STRING_TO_INT128_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset
`define DSI_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("dsi: implication check failed");
// Next-cycle implication, checked out of reset
`define DSI_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("dsi: next-cycle check failed");
`else
`define DSI_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define DSI_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif

`endif

// ===== src/dsi_pkg.sv =====
// ---------------------------------------------------------------------------
// dsi_pkg
// Types and constants of the decimal string to int128 parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsi_pkg;

  localparam int CharW  = 8;
  localparam int DigitW = 4;
  localparam int HalfW  = 64;
  localparam int MagW   = 2 * HalfW;
  localparam int ProdW  = MagW + 3;

  localparam logic [CharW-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;

  // Largest magnitude, only legal for a negative value
  localparam logic [MagW-1:0] MAG_LIMIT = {1'b1, {(MagW-1){1'b0}}};

  // Character class decided by the front end
  typedef enum logic [1:0] {
    KIND_DIGIT,
    KIND_MINUS,
    KIND_BAD,
    KIND_EMPTY
  } kind_t;

  // One classified character on its way to the accumulator
  typedef struct packed {
    kind_t             kind;
    logic [DigitW-1:0] digit;
    logic              last;
  } entry_t;

endpackage

// ===== src/dsi_if.sv =====
// ---------------------------------------------------------------------------
// dsi_if
// Valid/ready channels of the decimal string parser: characters in,
// 128-bit results out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dsi_in_if;
  import dsi_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             last;
  logic             empty_string;

  modport source (output valid, char_code, last, empty_string, input ready);
  modport sink   (input valid, char_code, last, empty_string, output ready);
endinterface

interface dsi_out_if;
  import dsi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic        [HalfW-1:0] value_low;
  logic signed [HalfW-1:0] value_high;
  logic                    error;

  modport source (output valid, value_low, value_high, error, input ready);
  modport sink   (input valid, value_low, value_high, error, output ready);
endinterface

// ===== src/dsi_front.sv =====
// ---------------------------------------------------------------------------
// dsi_front
// Accepts characters, tracks the first position of each string and
// classifies every character as digit, leading minus, bad or empty marker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsi_front (
  input  logic            clk,
  input  logic            rst_n,
  dsi_in_if.sink          in_ch,
  output logic            push_valid,
  output dsi_pkg::entry_t push_entry,
  input  logic            push_ready
);
  import dsi_pkg::*;

  logic at_start_r;
  logic at_start_nxt;
  logic is_digit;
  logic xfer;

  // Pass the handshake straight to the queue
  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;
  assign xfer        = in_ch.valid && push_ready;

  // Classify the character
  assign is_digit = (in_ch.char_code >= CHAR_ZERO) && (in_ch.char_code <= CHAR_NINE);

  always_comb begin
    push_entry.digit = DigitW'(in_ch.char_code - CHAR_ZERO);
    push_entry.last  = in_ch.last || in_ch.empty_string;
    priority if (in_ch.empty_string) begin
      push_entry.kind = KIND_EMPTY;
    end else if (at_start_r && (in_ch.char_code == CHAR_MINUS)) begin
      push_entry.kind = KIND_MINUS;
    end else if (is_digit) begin
      push_entry.kind = KIND_DIGIT;
    end else begin
      push_entry.kind = KIND_BAD;
    end
  end

  // Rearm the first-position flag at each string end
  always_comb begin
    at_start_nxt = at_start_r;
    if (xfer) begin
      at_start_nxt = in_ch.last || in_ch.empty_string;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
    end else begin
      at_start_r <= at_start_nxt;
    end
  end

endmodule

// ===== src/dsi_queue.sv =====
// ---------------------------------------------------------------------------
// dsi_queue
// Short FIFO of classified characters between front end and accumulator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decimal_string_to_int128_core_macros.svh"

module dsi_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  dsi_pkg::entry_t push_entry,
  output logic            push_ready,
  output logic            pop_valid,
  output dsi_pkg::entry_t pop_entry,
  input  logic            pop_ready
);
  import dsi_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  entry_t            mem_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              push;
  logic              pop;

  assign push_ready = (count_r != CntW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  `DSI_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CntW'(DEPTH))

endmodule

// ===== src/dsi_back.sv =====
// ---------------------------------------------------------------------------
// dsi_back
// Accumulates magnitude * 10 + digit with overflow check, and holds the
// finished result in an output register until it is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decimal_string_to_int128_core_macros.svh"

module dsi_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  input  dsi_pkg::entry_t pop_entry,
  output logic            pop_ready,
  dsi_out_if.source       out_ch
);
  import dsi_pkg::*;

  // Accumulation state
  logic [MagW-1:0]  mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic             failed_r, failed_nxt;
  logic             saw_r, saw_nxt;

  // Result register
  logic             res_valid_r, res_valid_nxt;
  logic [MagW-1:0]  res_mag_r, res_mag_nxt;
  logic             res_neg_r, res_neg_nxt;
  logic             res_err_r, res_err_nxt;

  logic             slot_free;
  logic             take;
  logic             ends;
  logic             err;
  logic             fits;
  logic [ProdW-1:0] prod;
  logic [MagW-1:0]  signed_val;

  // Hold the string end until the result slot is free
  assign slot_free = !res_valid_r || out_ch.ready;
  assign ends      = pop_entry.last;
  assign pop_ready = !ends || slot_free;
  assign take      = pop_valid && pop_ready;

  // Multiply by ten as shift and add, then check range
  assign prod = ({3'b000, mag_r} << 3) + ({3'b000, mag_r} << 1)
              + ProdW'(pop_entry.digit);
  assign fits = (prod[ProdW-1:MagW] == '0)
             && (!prod[MagW-1] || (neg_r && (prod[MagW-1:0] == MAG_LIMIT)));

  always_comb begin
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    failed_nxt    = failed_r;
    saw_nxt       = saw_r;
    res_valid_nxt = res_valid_r && !out_ch.ready;
    res_mag_nxt   = res_mag_r;
    res_neg_nxt   = res_neg_r;
    res_err_nxt   = res_err_r;
    err           = 1'b0;
    if (take) begin
      unique case (pop_entry.kind)
        KIND_DIGIT: begin
          saw_nxt = 1'b1;
          if (!failed_r) begin
            if (fits) begin
              mag_nxt = prod[MagW-1:0];
            end else begin
              failed_nxt = 1'b1;
            end
          end
        end
        KIND_MINUS: neg_nxt    = 1'b1;
        KIND_BAD:   failed_nxt = 1'b1;
        KIND_EMPTY: ;
        default:    ;
      endcase
      err = (pop_entry.kind == KIND_EMPTY) || failed_nxt || !saw_nxt;
      // Load the result and clear for the next string
      if (ends) begin
        res_valid_nxt = 1'b1;
        res_mag_nxt   = err ? '0 : mag_nxt;
        res_neg_nxt   = !err && neg_nxt;
        res_err_nxt   = err;
        mag_nxt       = '0;
        neg_nxt       = 1'b0;
        failed_nxt    = 1'b0;
        saw_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r       <= '0;
      neg_r       <= 1'b0;
      failed_r    <= 1'b0;
      saw_r       <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      mag_r       <= mag_nxt;
      neg_r       <= neg_nxt;
      failed_r    <= failed_nxt;
      saw_r       <= saw_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_mag_r <= res_mag_nxt;
    res_neg_r <= res_neg_nxt;
    res_err_r <= res_err_nxt;
  end

  // Apply the sign to the stored magnitude
  assign signed_val        = res_neg_r ? (~res_mag_r + 1'b1) : res_mag_r;
  assign out_ch.valid      = res_valid_r;
  assign out_ch.value_low  = signed_val[HalfW-1:0];
  assign out_ch.value_high = signed'(signed_val[MagW-1:HalfW]);
  assign out_ch.error      = res_err_r;

  `DSI_ASSERT_NXT(a_clear_after_end, clk, rst_n, take && ends, (mag_r == '0) && !neg_r && !failed_r && !saw_r)
  `DSI_ASSERT_IMP(a_err_zero, clk, rst_n, res_valid_r && res_err_r, (res_mag_r == '0) && !res_neg_r)
  `DSI_ASSERT_IMP(a_mag_range, clk, rst_n, mag_r[MagW-1], (mag_r[MagW-2:0] == '0) && neg_r)

endmodule

// ===== src/decimal_string_to_int128_core.sv =====
// ---------------------------------------------------------------------------
// decimal_string_to_int128_core
// Parses a decimal string, one character per transfer, into a signed
// 128-bit integer with an error flag.
//
// in_ch carries one ASCII character per transfer with last marking the end
// of a string; empty_string marks an empty string and always ends it.
// out_ch gives one result per string: the two's complement value as
// value_low / value_high (zero on error) and error.
// Throughput: one character per cycle, sustained while out_ch does not stall;
// set by the single multiply-by-ten-and-add step in the accumulator.
// The last character passes through the queue, then the accumulator loads
// the result register, which holds the result valid on out_ch until taken.
// When out_ch stalls, the result register holds; characters keep flowing
// into the accumulator until the next string end, after which the queue
// fills and in_ch.ready drops.
// Reset clears the queue, the accumulator and the result valid flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_string_to_int128_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  dsi_in_if.sink     in_ch,
  dsi_out_if.source  out_ch
);
  import dsi_pkg::*;

  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  // Classify incoming characters
  dsi_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  // Decouple front end and accumulator
  dsi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  // Accumulate and deliver results
  dsi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule
